FILE: rtl/core/gmt_pkg.sv
// Shared types, codes and defaults of the gossip membership table.
package gmt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PICK_W = 32;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MSG  = 2'd1;
  localparam logic [1:0] OP_PING = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [2:0] KIND_SYNC      = 3'd0;
  localparam logic [2:0] KIND_HEARTBEAT = 3'd1;
  localparam logic [2:0] KIND_LIST      = 3'd2;
  localparam logic [2:0] KIND_PONG      = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  localparam logic [1:0] ST_ALIVE   = 2'd0;
  localparam logic [1:0] ST_SUSPECT = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;

  localparam logic [1:0] REG_SELF_ID  = 2'd0;
  localparam logic [1:0] REG_SUSPECT  = 2'd1;
  localparam logic [1:0] REG_DEAD     = 2'd2;
  localparam logic [1:0] REG_INTERVAL = 2'd3;

  localparam logic [31:0] SUSPECT_RST  = 32'd15000;
  localparam logic [31:0] DEAD_RST     = 32'd30000;
  localparam logic [31:0] INTERVAL_RST = 32'd5000;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  status;
    logic [31:0] seen_ms;
    logic [63:0] incarnation;
    logic [63:0] cur_version;
    logic [63:0] top_version;
  } entry_t;

endpackage

FILE: rtl/core/gmt_mod_unit.sv
// Bit-serial remainder unit: random pick modulo eligible peer count.
module gmt_mod_unit
  import gmt_pkg::*;
#(
  parameter int DIV_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [PICK_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int STEP_W = $clog2(PICK_W + 1);

  logic [PICK_W-1:0] quo;
  logic [DIV_W-1:0]  div;
  logic [DIV_W:0]    acc;
  logic [DIV_W:0]    trial;
  logic [STEP_W-1:0] steps;
  logic              active;

  assign trial = {acc[DIV_W-1:0], quo[PICK_W-1]};
  assign rem   = acc[DIV_W-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (go) begin
      active <= 1'b1;
      steps  <= STEP_W'(PICK_W);
      quo    <= dividend;
      div    <= divisor;
      acc    <= '0;
    end else if (active) begin
      quo   <= quo << 1;
      steps <= steps - 1'b1;
      if (trial >= {1'b0, div}) acc <= trial - {1'b0, div};
      else acc <= trial;
      if (steps == STEP_W'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/gossip_membership_table_unit.sv
// Gossip membership table: peer table memory, aging, target choice and merging.
// Header or list entry: slots are compared in turn until the id matches, then merged;
// a list entry with the own id is ignored. Tick: each occupied slot is aged, then
// the interval is tested; when gossip is due, the remainder unit and the target scan run.
// Results leave one per cycle; at most two per transaction; the receiver cannot stall.
// Synchronous reset empties the table (fill count zero) and restores register defaults.
module gossip_membership_table_unit
  import gmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [31:0] now_ms,
  input  logic [31:0] peer_id,
  input  logic [31:0] peer_ip,
  input  logic [15:0] peer_port,
  input  logic [1:0]  peer_state,
  input  logic [63:0] peer_incarnation,
  input  logic [63:0] peer_current_version,
  input  logic [63:0] peer_highest_version,
  input  logic [63:0] local_version,
  input  logic [31:0] random_pick,
  input  logic [3:0]  list_roll,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port,
  output logic [63:0] range_first,
  output logic [63:0] range_last,
  output logic        last
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EV    = 3'd2;
  localparam logic [2:0] S_GOSS  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [1:0] M_AGE  = 2'd0;
  localparam logic [1:0] M_FIND = 2'd1;
  localparam logic [1:0] M_LOOK = 2'd2;

  logic [2:0]  state;
  logic [1:0]  mode;
  logic [31:0] self_id, suspect_ms, dead_ms, interval_ms, last_gossip;

  logic [1:0]  op_l, pst_l;
  logic [31:0] now_l, id_l, ip_l, pick_l;
  logic [15:0] port_l;
  logic [63:0] inc_l, cur_l, top_l, local_l;
  logic        roll_zero, due;

  logic [CNT_W-1:0] fill, idx, cnt, seen;
  logic [CNT_W-1:0] idx_inc;
  logic [IDX_W-1:0] hit_slot;
  logic        hit;
  entry_t      ent;

  entry_t      mem [TABLE_ENTRIES];
  entry_t      rd_data;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t      mem_wdata;

  logic        p_full, p_sync, p_pong, p_hb, p_list;
  logic [31:0] tgt_ip;
  logic [15:0] tgt_port;

  logic        mod_go;
  logic        mod_done;
  logic [CNT_W-1:0] mod_rem;

  entry_t      aged;
  logic [31:0] age;
  logic        rd_elig;
  logic        room;

  assign busy    = (state != S_IDLE);
  assign idx_inc = idx + 1'b1;
  assign room    = (fill < CNT_W'(TABLE_ENTRIES));
  assign age     = now_l - rd_data.seen_ms;
  assign rd_elig = (rd_data.id != self_id) && (rd_data.status != ST_DEAD);

  always_comb begin
    aged = rd_data;
    if (rd_data.id != self_id) begin
      if (rd_data.status == ST_ALIVE && age > suspect_ms) aged.status = ST_SUSPECT;
      else if (rd_data.status == ST_SUSPECT && age > dead_ms) aged.status = ST_DEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[idx[IDX_W-1:0]];
  end

  gmt_mod_unit #(.DIV_W(CNT_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (pick_l),
    .divisor  (cnt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    mod_go <= 1'b0;
    strobe <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      mode        <= M_AGE;
      fill        <= '0;
      last_gossip <= '0;
      self_id     <= '0;
      suspect_ms  <= SUSPECT_RST;
      dead_ms     <= DEAD_RST;
      interval_ms <= INTERVAL_RST;
      p_full <= 1'b0; p_sync <= 1'b0; p_pong <= 1'b0; p_hb <= 1'b0; p_list <= 1'b0;
      idx <= '0; cnt <= '0; seen <= '0; hit <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SELF_ID:  self_id     <= cfg_data;
          REG_SUSPECT:  suspect_ms  <= cfg_data;
          REG_DEAD:     dead_ms     <= cfg_data;
          REG_INTERVAL: interval_ms <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_l <= operation; now_l <= now_ms; id_l <= peer_id; ip_l <= peer_ip;
            port_l <= peer_port; pst_l <= peer_state; inc_l <= peer_incarnation;
            cur_l <= peer_current_version; top_l <= peer_highest_version;
            local_l <= local_version; pick_l <= random_pick;
            roll_zero <= (list_roll == 4'd0);
            due <= ((now_ms - last_gossip) >= interval_ms);
            idx <= '0; cnt <= '0; hit <= 1'b0;
            if (operation == OP_TICK) begin
              mode  <= M_AGE;
              state <= (fill == '0) ? S_GOSS : S_RD;
            end else if (operation == OP_LIST && peer_id == self_id) begin
              state <= S_EMIT;
            end else begin
              mode  <= M_LOOK;
              state <= (fill == '0) ? S_APPLY : S_RD;
            end
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          state <= S_RD;
          idx   <= idx_inc;
          case (mode)
            M_AGE: begin
              mem_we    <= 1'b1;
              mem_waddr <= idx[IDX_W-1:0];
              mem_wdata <= aged;
              if (aged.id != self_id && aged.status != ST_DEAD) cnt <= cnt + 1'b1;
              if (idx_inc == fill) state <= S_GOSS;
            end
            M_FIND: begin
              if (rd_elig) begin
                seen <= seen + 1'b1;
                if (seen == cnt) begin
                  tgt_ip   <= rd_data.ip;
                  tgt_port <= rd_data.port;
                  p_hb     <= (rd_data.ip != '0);
                  p_list   <= (rd_data.ip != '0) && roll_zero;
                  state    <= S_EMIT;
                end
              end
            end
            default: begin
              if (rd_data.id == id_l) begin
                hit      <= 1'b1;
                ent      <= rd_data;
                hit_slot <= idx[IDX_W-1:0];
                state    <= S_APPLY;
              end else if (idx_inc == fill) begin
                state <= S_APPLY;
              end
            end
          endcase
        end
        S_GOSS: begin
          if (!due) begin
            state <= S_EMIT;
          end else begin
            last_gossip <= now_l;
            if (cnt == '0) state <= S_EMIT;
            else begin
              mod_go <= 1'b1;
              state  <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            cnt   <= mod_rem;
            seen  <= '0;
            idx   <= '0;
            mode  <= M_FIND;
            state <= S_RD;
          end
        end
        S_APPLY: begin
          state <= S_EMIT;
          mem_wdata.id      <= id_l;
          mem_wdata.ip      <= ip_l;
          mem_wdata.port    <= port_l;
          // a listed peer already known keeps its last-seen time
          mem_wdata.seen_ms <= (op_l == OP_LIST && hit) ? ent.seen_ms : now_l;
          mem_wdata.incarnation <= inc_l;
          mem_wdata.cur_version <= cur_l;
          if (op_l != OP_LIST) begin
            mem_wdata.status      <= ST_ALIVE;
            mem_wdata.top_version <= (hit && ent.top_version >= cur_l) ?
                                     ent.top_version : cur_l;
            p_pong <= (op_l == OP_PING);
            if (hit) begin
              mem_we <= 1'b1; mem_waddr <= hit_slot; p_sync <= (cur_l > local_l);
            end else if (room) begin
              mem_we <= 1'b1; mem_waddr <= fill[IDX_W-1:0]; fill <= fill + 1'b1;
              p_sync <= (cur_l > local_l);
            end else begin
              p_full <= 1'b1;
            end
          end else begin
            mem_wdata.status      <= pst_l;
            mem_wdata.top_version <= top_l;
            if (hit) begin
              p_sync <= (cur_l > local_l);
              if (ent.incarnation < inc_l) begin
                mem_we <= 1'b1; mem_waddr <= hit_slot;
              end
            end else if (pst_l != ST_DEAD) begin
              if (room) begin
                mem_we <= 1'b1; mem_waddr <= fill[IDX_W-1:0]; fill <= fill + 1'b1;
                p_sync <= (cur_l > local_l);
              end else begin
                p_full <= 1'b1;
              end
            end
          end
        end
        S_EMIT: begin
          kind <= KIND_SYNC; dest_ip <= '0; dest_port <= '0;
          range_first <= '0; range_last <= '0;
          if (p_full) begin
            strobe <= 1'b1; kind <= KIND_FULL; p_full <= 1'b0;
            last <= !(p_sync || p_pong || p_hb || p_list);
          end else if (p_sync) begin
            strobe <= 1'b1; kind <= KIND_SYNC; p_sync <= 1'b0;
            range_first <= local_l + 64'd1; range_last <= cur_l;
            last <= !(p_pong || p_hb || p_list);
          end else if (p_pong) begin
            strobe <= 1'b1; kind <= KIND_PONG; p_pong <= 1'b0;
            dest_ip <= ip_l; dest_port <= port_l;
            last <= !(p_hb || p_list);
          end else if (p_hb) begin
            strobe <= 1'b1; kind <= KIND_HEARTBEAT; p_hb <= 1'b0;
            dest_ip <= tgt_ip; dest_port <= tgt_port;
            last <= !p_list;
          end else if (p_list) begin
            strobe <= 1'b1; kind <= KIND_LIST; p_list <= 1'b0;
            dest_ip <= tgt_ip; dest_port <= tgt_port;
            last <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_ENTRIES)) else $error("fill count beyond table");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside a transaction");
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("result after final result");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction not taken up");
`endif

endmodule

FILE: dv/tb_gossip_membership_table_unit.sv
// Testbench for the gossip membership table: random and directed transactions.
`timescale 1ns / 100ps

module tb_gossip_membership_table_unit
  import gmt_pkg::*;
();

  localparam int N_SLOTS = TABLE_ENTRIES_DEF;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] id;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  pstate;
    logic [63:0] inc;
    logic [63:0] cur;
    logic [63:0] top;
    logic [63:0] local_ver;
    logic [31:0] pick;
    logic [3:0]  roll;
  } msg_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] first;
    logic [63:0] lastv;
    logic        last;
  } send_t;

  class membership_sb;
    bit          used[N_SLOTS];
    entry_t      slot[N_SLOTS];
    logic [31:0] gossip_ms;
    logic [31:0] self_id, suspect_ms, dead_ms, interval_ms;
    send_t       sends_due[$];
    send_t       batch[$];
    int          errors;

    function new();
      for (int i = 0; i < N_SLOTS; i++) used[i] = 0;
      gossip_ms = 0;
      self_id = 0;
      suspect_ms = SUSPECT_RST;
      dead_ms = DEAD_RST;
      interval_ms = INTERVAL_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_SELF_ID: self_id = v;
        REG_SUSPECT: suspect_ms = v;
        REG_DEAD: dead_ms = v;
        default: interval_ms = v;
      endcase
    endfunction

    function void add(logic [2:0] k, logic [31:0] ip, logic [15:0] port,
                      logic [63:0] f, logic [63:0] l);
      send_t s;
      s.kind = k; s.ip = ip; s.port = port; s.first = f; s.lastv = l; s.last = 0;
      batch.push_back(s);
    endfunction

    function int find_slot(logic [31:0] id);
      for (int i = 0; i < N_SLOTS; i++) if (used[i] && slot[i].id == id) return i;
      return -1;
    endfunction

    function int claim_slot(logic [31:0] id, logic [31:0] ip, logic [15:0] port,
                            logic [31:0] now);
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!used[i]) begin
          used[i] = 1;
          slot[i] = '0;
          slot[i].id = id; slot[i].ip = ip; slot[i].port = port;
          slot[i].status = ST_ALIVE; slot[i].seen_ms = now;
          return i;
        end
      end
      return -1;
    endfunction

    function bit can_target(int i);
      return used[i] && slot[i].id != self_id && slot[i].status != ST_DEAD;
    endfunction

    function void tick(msg_t m);
      logic [31:0] age, cnt, idx, seen;
      cnt = 0; seen = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!used[i] || slot[i].id == self_id) continue;
        age = m.now - slot[i].seen_ms;
        if (slot[i].status == ST_ALIVE && age > suspect_ms) slot[i].status = ST_SUSPECT;
        else if (slot[i].status == ST_SUSPECT && age > dead_ms) slot[i].status = ST_DEAD;
      end
      if (32'(m.now - gossip_ms) < interval_ms) return;
      for (int i = 0; i < N_SLOTS; i++) if (can_target(i)) cnt++;
      if (cnt != 0) begin
        idx = m.pick % cnt;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!can_target(i)) continue;
          if (seen == idx) begin
            if (slot[i].ip != 0) begin
              add(KIND_HEARTBEAT, slot[i].ip, slot[i].port, 0, 0);
              if (m.roll == 0) add(KIND_LIST, slot[i].ip, slot[i].port, 0, 0);
            end
            break;
          end
          seen++;
        end
      end
      gossip_ms = m.now;
    endfunction

    function void note_input(msg_t m);
      int s;
      batch.delete();
      if (m.op == OP_TICK) begin
        tick(m);
      end else if (m.op == OP_MSG || m.op == OP_PING) begin
        s = find_slot(m.id);
        if (s < 0) begin
          s = claim_slot(m.id, m.ip, m.port, m.now);
          if (s < 0) add(KIND_FULL, 0, 0, 0, 0);
        end
        if (s >= 0) begin
          slot[s].seen_ms = m.now;
          slot[s].incarnation = m.inc;
          slot[s].ip = m.ip;
          slot[s].port = m.port;
          slot[s].cur_version = m.cur;
          if (m.cur > slot[s].top_version) slot[s].top_version = m.cur;
          if (m.cur > m.local_ver) add(KIND_SYNC, 0, 0, m.local_ver + 64'd1, m.cur);
          slot[s].status = ST_ALIVE;
        end
        if (m.op == OP_PING) add(KIND_PONG, m.ip, m.port, 0, 0);
      end else if (m.id != self_id) begin
        s = find_slot(m.id);
        if (s < 0 && m.pstate != ST_DEAD) begin
          s = claim_slot(m.id, m.ip, m.port, m.now);
          if (s < 0) add(KIND_FULL, 0, 0, 0, 0);
          else begin
            slot[s].incarnation = m.inc; slot[s].status = m.pstate;
            slot[s].cur_version = m.cur; slot[s].top_version = m.top;
          end
        end else if (s >= 0 && slot[s].incarnation < m.inc) begin
          slot[s].ip = m.ip; slot[s].port = m.port; slot[s].incarnation = m.inc;
          slot[s].status = m.pstate; slot[s].cur_version = m.cur;
          slot[s].top_version = m.top;
        end
        if (s >= 0 && m.cur > m.local_ver) add(KIND_SYNC, 0, 0, m.local_ver + 64'd1, m.cur);
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1;
      foreach (batch[i]) sends_due.push_back(batch[i]);
    endfunction

    function void check_result(send_t got);
      send_t e;
      if (sends_due.size() == 0) begin
        $display("%0t: unexpected result kind %0d ip %h", $time, got.kind, got.ip);
        errors++;
        return;
      end
      e = sends_due.pop_front();
      if (got.kind !== e.kind || got.ip !== e.ip || got.port !== e.port ||
          got.first !== e.first || got.lastv !== e.lastv || got.last !== e.last) begin
        $display("%0t: mismatch exp kind %0d ip %h port %h first %h last_ver %h last %b",
                 $time, e.kind, e.ip, e.port, e.first, e.lastv, e.last);
        $display("%0t:          got kind %0d ip %h port %h first %h last_ver %h last %b",
                 $time, got.kind, got.ip, got.port, got.first, got.lastv, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [1:0]  operation = '0;
  logic [31:0] now_ms = '0, peer_id = '0, peer_ip = '0;
  logic [15:0] peer_port = '0;
  logic [1:0]  peer_state = '0;
  logic [63:0] peer_incarnation = '0, peer_current_version = '0;
  logic [63:0] peer_highest_version = '0, local_version = '0;
  logic [31:0] random_pick = '0;
  logic [3:0]  list_roll = '0;
  logic        strobe;
  logic [2:0]  kind;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [63:0] range_first, range_last;
  logic        last;

  membership_sb sb = new();
  logic [31:0]  clock_ms = 0;
  logic [31:0]  id_pool[20];
  int           idle_pct = 0;

  gossip_membership_table_unit DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    send_t r;
    if (!rst && strobe) begin
      r.kind = kind; r.ip = dest_ip; r.port = dest_port;
      r.first = range_first; r.lastv = range_last; r.last = last;
      sb.check_result(r);
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand_ver();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom(), $urandom()};
      default: return 64'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic issue(msg_t m);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    operation <= m.op; now_ms <= m.now; peer_id <= m.id; peer_ip <= m.ip;
    peer_port <= m.port; peer_state <= m.pstate; peer_incarnation <= m.inc;
    peer_current_version <= m.cur; peer_highest_version <= m.top;
    local_version <= m.local_ver; random_pick <= m.pick; list_roll <= m.roll;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_input(m);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.sends_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  function automatic msg_t rand_msg();
    msg_t m;
    clock_ms = clock_ms + ($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 4000));
    m.op = 2'($urandom_range(0, 3));
    m.now = clock_ms;
    m.id = ($urandom_range(0, 19) == 0) ? $urandom() : id_pool[$urandom_range(0, 19)];
    m.ip = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
    m.port = 16'($urandom());
    m.pstate = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    m.inc = rand_ver(); m.cur = rand_ver(); m.top = rand_ver(); m.local_ver = rand_ver();
    m.pick = $urandom();
    m.roll = 4'($urandom_range(0, 9));
    return m;
  endfunction

  initial begin
    msg_t m;
    int pct[5] = '{0, 56, 0, 13, 56};
    for (int i = 0; i < 20; i++) id_pool[i] = (i == 19) ? 32'hFFFF_FFFF : 32'(i * 7 + 1);
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: new peers, zero address, ping, list cases, ticks, version extremes
    m = '{op: OP_MSG, now: 32'd100, id: 32'd1, ip: 32'd0, port: 16'd0, pstate: ST_ALIVE,
          inc: 64'd0, cur: 64'd0, top: 64'd0, local_ver: 64'd0, pick: 32'd0, roll: 4'd0};
    issue(m);
    m.op = OP_TICK; m.now = 32'd6000; issue(m);
    m.op = OP_PING; m.id = 32'd8; m.ip = '1; m.port = '1; m.inc = '1; m.cur = '1;
    m.local_ver = 64'hFFFF_FFFF_FFFF_FFFE; issue(m);
    m.op = OP_LIST; m.id = 32'd15; m.pstate = ST_DEAD; m.local_ver = 64'd0; issue(m);
    m.id = 32'd0; m.pstate = ST_ALIVE; issue(m);
    m.id = 32'd22; m.pstate = 2'd3; m.top = '1; issue(m);
    m.id = 32'd29; m.pstate = ST_SUSPECT; m.cur = 64'd5; m.local_ver = 64'd9; issue(m);
    m.id = 32'd8; m.inc = 64'd1; issue(m);
    m.op = OP_TICK; m.now = 32'd12000; m.pick = '1; m.roll = 4'd9; issue(m);
    m.now = 32'd50000; m.roll = 4'd8; issue(m);
    m.now = 32'd90000; m.roll = 4'd0; m.pick = 32'd3; issue(m);
    m.now = 32'hFFFF_FFF0; issue(m);
    m.now = 32'd40; issue(m);
    m.op = OP_MSG; m.id = 32'd29; m.now = 32'd50; m.cur = 64'd10; m.local_ver = 64'd9; issue(m);
    clock_ms = 32'd100;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SUSPECT, 32'd3000); write_reg(REG_DEAD, 32'd6000);
          write_reg(REG_INTERVAL, 32'd0); write_reg(REG_SELF_ID, id_pool[2]);
        end
        1: begin
          write_reg(REG_SUSPECT, 32'd0); write_reg(REG_DEAD, 32'd0);
          write_reg(REG_INTERVAL, 32'hFFFF_FFFF); write_reg(REG_SELF_ID, 32'd0);
        end
        2: begin
          write_reg(REG_SUSPECT, 32'hFFFF_FFFF); write_reg(REG_DEAD, 32'hFFFF_FFFF);
          write_reg(REG_INTERVAL, 32'd1000); write_reg(REG_SELF_ID, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_SUSPECT, 32'd15000); write_reg(REG_DEAD, 32'd30000);
          write_reg(REG_INTERVAL, 32'd5000); write_reg(REG_SELF_ID, id_pool[5]);
        end
        default: begin
          write_reg(REG_SUSPECT, 32'd2000); write_reg(REG_DEAD, 32'd2500);
          write_reg(REG_INTERVAL, 32'd0); write_reg(REG_SELF_ID, id_pool[0]);
        end
      endcase
      idle_pct = pct[ph];
      for (int n = 0; n < 340; n++) begin
        if (ph == 1 && n == 170) begin
          start <= 0;
          @(posedge clk);
          while (sb.sends_due.size() != 0) @(posedge clk);
        end
        issue(rand_msg());
      end
      drain();
    end

    if (sb.errors == 0 && sb.sends_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gmt_pkg.sv
rtl/core/gmt_mod_unit.sv
rtl/core/gossip_membership_table_unit.sv
dv/tb_gossip_membership_table_unit.sv
